[sv/assert_macros.svh]
// assertion macros shared by the address resolution cache rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ARC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("arc assertion failed");
`define ARC_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("arc forbidden condition seen");
`else
`define ARC_ASSERT(lbl, clk, rst, prop)
`define ARC_NEVER(lbl, clk, rst, cond)
`endif
`endif

[sv/arc_pkg.sv]
// types and constants of the address resolution cache
// no dependencies; used by the channel interfaces and the core
package arc_pkg;

   localparam int unsigned OPCODE_W     = 3;
   localparam int unsigned ADDR_W       = 64;
   localparam int unsigned IID_W        = 64;
   localparam int unsigned LOC_W        = 16;
   localparam int unsigned RID_W        = 6;
   localparam int unsigned CNT_W        = 8;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned ACT_W        = 2;
   localparam int unsigned ROUTER_SHIFT = 10;

   localparam logic [OPCODE_W-1:0] OP_RESOLVE = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_NOTIFY  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_UNREACH = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_PENDING = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NONE    = 2'd3;

   localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
   localparam logic [ACT_W-1:0] ACT_ACK   = 2'd2;
   localparam logic [ACT_W-1:0] ACT_ERROR = 2'd3;

   localparam logic [CNT_W-1:0] TIMEOUT_RESET = 8'd3;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } arc_state_type;

endpackage

[sv/arc_req_if.sv]
// request channel of the address resolution cache: valid, ready, request word
// depends on arc_pkg
interface arc_req_if import arc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ADDR_W-1:0]   target_high;
   logic [ADDR_W-1:0]   target_low;
   logic [IID_W-1:0]    iid;
   logic [LOC_W-1:0]    locator;
   logic [RID_W-1:0]    router_num;

   modport source (output valid, opcode, target_high, target_low, iid, locator, router_num,
                   input ready);
   modport sink (input valid, opcode, target_high, target_low, iid, locator, router_num,
                 output ready);
endinterface

[sv/arc_rsp_if.sv]
// response channel of the address resolution cache: valid, ready, response word
// depends on arc_pkg
interface arc_rsp_if import arc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LOC_W-1:0]    locator_out;
   logic [ACT_W-1:0]    action;
   logic                timer_active;

   modport source (output valid, status, locator_out, action, timer_active, input ready);
   modport sink (input valid, status, locator_out, action, timer_active, output ready);
endinterface

[sv/address_resolution_cache_core.sv]
// address resolution cache core: entry table, scan sequencer, response register
// depends on arc_pkg, arc_req_if, arc_rsp_if and assert_macros.svh
//
// usage:
//   req_ch carries one request word (opcode, target, iid, locator, router id).
//   rsp_ch returns exactly one response word per request, in order.
//   csr_wr_en/csr_wr_data write the discovery timeout; a zero write stores one.
//   write the timeout only while no request is in flight.
// timing:
//   a request is taken in idle, then one compare unit visits the entries one
//   per cycle through the registered table read port, then the finish state
//   applies the table update and loads the response. a new request is taken
//   only in idle, once the previous one has left the finish state.
// reset:
//   synchronous; all entries invalid and blank, timeout back to three.
// stall:
//   a waiting response sits in its output register while the next request is
//   taken and scanned; the finish cycle holds until that register is free.
`include "assert_macros.svh"

module address_resolution_cache_core import arc_pkg::*; #(
   parameter int unsigned ENTRIES = 8
) (
   input  logic             clock,
   input  logic             reset,
   arc_req_if.sink          req_ch,
   arc_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   // table memories
   logic [ADDR_W-1:0] thi_mem [ENTRIES];
   logic [ADDR_W-1:0] tlo_mem [ENTRIES];
   logic [IID_W-1:0]  iid_mem [ENTRIES];
   logic [LOC_W-1:0]  loc_mem [ENTRIES];
   logic [CNT_W-1:0]  cnt_mem [ENTRIES];

   arc_state_type state_ff, state_in;

   logic [OPCODE_W-1:0] op_ff;
   logic [ADDR_W-1:0]   thi_ff, tlo_ff;
   logic [IID_W-1:0]    iid_ff;
   logic [LOC_W-1:0]    loc_ff;
   logic [RID_W-1:0]    rid_ff;

   logic [CW-1:0] scan_ff, scan_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic [IW-1:0] rd_addr;

   logic [ADDR_W-1:0] thi_rd_ff, tlo_rd_ff;
   logic [IID_W-1:0]  iid_rd_ff;
   logic [LOC_W-1:0]  loc_rd_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;

   logic [ENTRIES-1:0] disc_ff, disc_in;
   logic [ENTRIES-1:0] vld_ff, vld_in;
   logic [ENTRIES-1:0] twr_ff, twr_in;
   logic [ENTRIES-1:0] iwr_ff, iwr_in;

   logic             found_ff, found_in;
   logic [IW-1:0]    pick_ff, pick_in;
   logic             pick_vld_ff, pick_vld_in;
   logic             iid_eq_ff, iid_eq_in;
   logic [LOC_W-1:0] hit_loc_ff, hit_loc_in;
   logic             free_ff, free_in;
   logic [IW-1:0]    free_idx_ff, free_idx_in;

   logic [CNT_W-1:0] timeout_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [LOC_W-1:0]    rsp_loc_ff, rsp_loc_in;
   logic [ACT_W-1:0]    rsp_act_ff, rsp_act_in;
   logic                rsp_tmr_ff, rsp_tmr_in;

   logic             tgt_we, inf_we, cnt_we;
   logic [IW-1:0]    cnt_wa;
   logic [CNT_W-1:0] cnt_wd;

   logic              req_take, fin_go;
   logic              e_inv, t_match;
   logic [ADDR_W-1:0] thi_eff, tlo_eff;
   logic [IID_W-1:0]  iid_eff;
   logic [LOC_W-1:0]  loc_eff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign fin_go       = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ch.ready);
   assign rd_addr      = scan_ff[IW-1:0];

   // never-written entries read as zero
   assign thi_eff = twr_ff[chk_idx_ff] ? thi_rd_ff : '0;
   assign tlo_eff = twr_ff[chk_idx_ff] ? tlo_rd_ff : '0;
   assign iid_eff = iwr_ff[chk_idx_ff] ? iid_rd_ff : '0;
   assign loc_eff = iwr_ff[chk_idx_ff] ? loc_rd_ff : '0;
   assign e_inv   = !disc_ff[chk_idx_ff] && !vld_ff[chk_idx_ff];
   assign t_match = (thi_eff == thi_ff) && (tlo_eff == tlo_ff);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.locator_out  = rsp_loc_ff;
   assign rsp_ch.action       = rsp_act_ff;
   assign rsp_ch.timer_active = rsp_tmr_ff;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      disc_in       = disc_ff;
      vld_in        = vld_ff;
      twr_in        = twr_ff;
      iwr_in        = iwr_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      pick_vld_in   = pick_vld_ff;
      iid_eq_in     = iid_eq_ff;
      hit_loc_in    = hit_loc_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_loc_in    = rsp_loc_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_tmr_in    = rsp_tmr_ff;
      tgt_we        = 1'b0;
      inf_we        = 1'b0;
      cnt_we        = 1'b0;
      cnt_wa        = chk_idx_ff;
      cnt_wd        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_SCAN;
               scan_in  = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
            end
         end
         S_SCAN: begin
            if (scan_ff != CW'(ENTRIES)) begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[IW-1:0];
               scan_in    = scan_ff + CW'(1);
            end else if (!chk_vld_ff) begin
               state_in = S_FINISH;
            end
            if (chk_vld_ff) begin
               case (op_ff)
                  OP_RESOLVE: begin
                     if (!found_ff) begin
                        if (!e_inv && t_match) begin
                           found_in    = 1'b1;
                           pick_in     = chk_idx_ff;
                           pick_vld_in = vld_ff[chk_idx_ff];
                           hit_loc_in  = loc_eff;
                        end else if (e_inv && !free_ff) begin
                           free_in     = 1'b1;
                           free_idx_in = chk_idx_ff;
                        end
                     end
                  end
                  OP_NOTIFY: begin
                     if (!found_ff && t_match) begin
                        found_in    = 1'b1;
                        pick_in     = chk_idx_ff;
                        pick_vld_in = vld_ff[chk_idx_ff];
                        iid_eq_in   = (iid_eff == iid_ff);
                     end
                  end
                  OP_REMOVE: begin
                     if (loc_eff[LOC_W-1:ROUTER_SHIFT] == rid_ff) begin
                        disc_in[chk_idx_ff] = 1'b0;
                        vld_in[chk_idx_ff]  = 1'b0;
                     end
                  end
                  OP_TICK: begin
                     if (disc_ff[chk_idx_ff]) begin
                        cnt_we = 1'b1;
                        cnt_wd = cnt_rd_ff - 8'd1;
                        if (cnt_rd_ff == 8'd1) begin
                           disc_in[chk_idx_ff] = 1'b0;
                        end
                     end
                  end
                  OP_UNREACH: begin
                     if (!found_ff && !e_inv && t_match) begin
                        found_in            = 1'b1;
                        disc_in[chk_idx_ff] = 1'b0;
                        vld_in[chk_idx_ff]  = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FINISH: begin
            if (fin_go) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_DONE;
               rsp_loc_in    = '0;
               rsp_act_in    = ACT_NONE;
               case (op_ff)
                  OP_RESOLVE: begin
                     if (found_ff) begin
                        if (pick_vld_ff) begin
                           rsp_loc_in = hit_loc_ff;
                        end else begin
                           rsp_status_in = STAT_PENDING;
                        end
                     end else if (free_ff) begin
                        tgt_we               = 1'b1;
                        twr_in[free_idx_ff]  = 1'b1;
                        disc_in[free_idx_ff] = 1'b1;
                        cnt_we               = 1'b1;
                        cnt_wa               = free_idx_ff;
                        cnt_wd               = timeout_ff;
                        rsp_status_in        = STAT_PENDING;
                        rsp_act_in           = ACT_QUERY;
                     end else begin
                        rsp_status_in = STAT_FULL;
                     end
                  end
                  OP_NOTIFY: begin
                     if (!found_ff) begin
                        rsp_status_in = STAT_NONE;
                     end else if (pick_vld_ff && !iid_eq_ff) begin
                        rsp_act_in = ACT_ERROR;
                     end else begin
                        inf_we           = 1'b1;
                        iwr_in[pick_ff]  = 1'b1;
                        vld_in[pick_ff]  = 1'b1;
                        disc_in[pick_ff] = 1'b0;
                        cnt_we           = 1'b1;
                        cnt_wa           = pick_ff;
                        cnt_wd           = '0;
                        rsp_act_in       = ACT_ACK;
                     end
                  end
                  OP_UNREACH: begin
                     if (!found_ff) begin
                        rsp_status_in = STAT_NONE;
                     end
                  end
                  OP_CLEAR: begin
                     disc_in = '0;
                     vld_in  = '0;
                     twr_in  = '0;
                     iwr_in  = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_tmr_in = |disc_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         disc_ff      <= '0;
         vld_ff       <= '0;
         twr_ff       <= '0;
         iwr_ff       <= '0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         chk_vld_ff   <= chk_vld_in;
         disc_ff      <= disc_in;
         vld_ff       <= vld_in;
         twr_ff       <= twr_in;
         iwr_ff       <= iwr_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= (csr_wr_data == '0) ? 8'd1 : csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_ch.opcode;
         thi_ff <= req_ch.target_high;
         tlo_ff <= req_ch.target_low;
         iid_ff <= req_ch.iid;
         loc_ff <= req_ch.locator;
         rid_ff <= req_ch.router_num;
      end
      chk_idx_ff    <= chk_idx_in;
      pick_ff       <= pick_in;
      pick_vld_ff   <= pick_vld_in;
      iid_eq_ff     <= iid_eq_in;
      hit_loc_ff    <= hit_loc_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_loc_ff    <= rsp_loc_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_tmr_ff    <= rsp_tmr_in;
   end

   // table read port
   always_ff @(posedge clock) begin
      thi_rd_ff <= thi_mem[rd_addr];
      tlo_rd_ff <= tlo_mem[rd_addr];
      iid_rd_ff <= iid_mem[rd_addr];
      loc_rd_ff <= loc_mem[rd_addr];
      cnt_rd_ff <= cnt_mem[rd_addr];
   end

   // table write ports
   always_ff @(posedge clock) begin
      if (tgt_we) begin
         thi_mem[free_idx_ff] <= thi_ff;
         tlo_mem[free_idx_ff] <= tlo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (inf_we) begin
         iid_mem[pick_ff] <= iid_ff;
         loc_mem[pick_ff] <= loc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
   end

   `ARC_NEVER(a_state_excl, clock, reset, (disc_ff & vld_ff) != '0)
   `ARC_NEVER(a_scan_range, clock, reset, scan_ff > CW'(ENTRIES))
   `ARC_NEVER(a_timeout_nz, clock, reset, timeout_ff == '0)
   `ARC_ASSERT(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
   `ARC_ASSERT(a_query_timer, clock, reset, (rsp_valid_ff && rsp_act_ff == ACT_QUERY) |-> rsp_tmr_ff)

endmodule

[tb/arc_table_checker.sv]
// checker for the address resolution cache: watches both channels and the timeout write,
// keeps its own copy of the entry table and compares each response word with its prediction
// depends on arc_pkg, arc_req_if and arc_rsp_if
module arc_table_checker import arc_pkg::*; #(
   parameter int unsigned ENTRIES = 8
) (
   input  logic             clock,
   input  logic             reset,
   arc_req_if               req_ch,
   arc_rsp_if               rsp_ch,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   output int               mismatch_count,
   output int               expected_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 40;

   typedef enum logic [1:0] {
      ENTRY_INVALID  = 2'd0,
      ENTRY_DISCOVER = 2'd1,
      ENTRY_VALID    = 2'd2
   } entry_state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LOC_W-1:0]    locator;
      logic [ACT_W-1:0]    action;
      logic                timer_active;
   } arc_result_type;

   logic [ADDR_W-1:0] tbl_hi    [ENTRIES];
   logic [ADDR_W-1:0] tbl_lo    [ENTRIES];
   logic [IID_W-1:0]  tbl_iid   [ENTRIES];
   logic [LOC_W-1:0]  tbl_loc   [ENTRIES];
   entry_state_type   tbl_state [ENTRIES];
   logic [CNT_W-1:0]  tbl_count [ENTRIES];
   logic [CNT_W-1:0]  timeout_setting;

   arc_result_type pending_results[$];

   function automatic void wipe_entries();
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_hi[i]    = '0;
         tbl_lo[i]    = '0;
         tbl_iid[i]   = '0;
         tbl_loc[i]   = '0;
         tbl_state[i] = ENTRY_INVALID;
         tbl_count[i] = '0;
      end
   endfunction

   function automatic arc_result_type apply_request(
      input logic [OPCODE_W-1:0] op,
      input logic [ADDR_W-1:0]   hi,
      input logic [ADDR_W-1:0]   lo,
      input logic [IID_W-1:0]    iid,
      input logic [LOC_W-1:0]    loc,
      input logic [RID_W-1:0]    rid
   );
      arc_result_type r;
      int             pick;
      bit             found;
      r = '0;
      pick = -1;
      found = 1'b0;
      case (op)
         OP_RESOLVE: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (!found) begin
                  if (tbl_state[i] != ENTRY_INVALID) begin
                     if (tbl_hi[i] == hi && tbl_lo[i] == lo) begin
                        pick = i;
                        found = 1'b1;
                     end
                  end else if (pick < 0) begin
                     pick = i;
                  end
               end
            end
            if (pick < 0) begin
               r.status = STAT_FULL;
            end else if (tbl_state[pick] == ENTRY_INVALID) begin
               tbl_hi[pick]    = hi;
               tbl_lo[pick]    = lo;
               tbl_state[pick] = ENTRY_DISCOVER;
               tbl_count[pick] = timeout_setting;
               r.status = STAT_PENDING;
               r.action = ACT_QUERY;
            end else if (tbl_state[pick] == ENTRY_VALID) begin
               r.locator = tbl_loc[pick];
            end else begin
               r.status = STAT_PENDING;
            end
         end
         OP_NOTIFY: begin
            r.status = STAT_NONE;
            for (int i = 0; i < ENTRIES; i++) begin
               if (!found && tbl_hi[i] == hi && tbl_lo[i] == lo) begin
                  found = 1'b1;
                  r.status = STAT_DONE;
                  if (tbl_state[i] != ENTRY_VALID || tbl_iid[i] == iid) begin
                     tbl_iid[i]   = iid;
                     tbl_loc[i]   = loc;
                     tbl_count[i] = '0;
                     tbl_state[i] = ENTRY_VALID;
                     r.action = ACT_ACK;
                  end else begin
                     r.action = ACT_ERROR;
                  end
               end
            end
         end
         OP_REMOVE: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_loc[i][LOC_W-1:ROUTER_SHIFT] == rid) tbl_state[i] = ENTRY_INVALID;
            end
         end
         OP_TICK: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_state[i] == ENTRY_DISCOVER) begin
                  tbl_count[i] = tbl_count[i] - 1'b1;
                  if (tbl_count[i] == '0) tbl_state[i] = ENTRY_INVALID;
               end
            end
         end
         OP_UNREACH: begin
            r.status = STAT_NONE;
            for (int i = 0; i < ENTRIES; i++) begin
               if (!found && tbl_state[i] != ENTRY_INVALID && tbl_hi[i] == hi
                   && tbl_lo[i] == lo) begin
                  found = 1'b1;
                  tbl_state[i] = ENTRY_INVALID;
                  r.status = STAT_DONE;
               end
            end
         end
         OP_CLEAR: begin
            wipe_entries();
         end
         default: begin
         end
      endcase
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_state[i] == ENTRY_DISCOVER) r.timer_active = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : monitor
      arc_result_type got;
      arc_result_type want;
      if (reset) begin
         wipe_entries();
         timeout_setting = TIMEOUT_RESET;
         pending_results.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status       = rsp_ch.status;
            got.locator      = rsp_ch.locator_out;
            got.action       = rsp_ch.action;
            got.timer_active = rsp_ch.timer_active;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected response word", '0, 64'(got));
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 64'(want.status), 64'(got.status));
               if (got.locator !== want.locator)
                  report_mismatch("locator_out", 64'(want.locator), 64'(got.locator));
               if (got.action !== want.action)
                  report_mismatch("action", 64'(want.action), 64'(got.action));
               if (got.timer_active !== want.timer_active)
                  report_mismatch("timer_active", 64'(want.timer_active),
                                  64'(got.timer_active));
            end
         end
         if (csr_wr_en) timeout_setting = (csr_wr_data == '0) ? CNT_W'(1) : csr_wr_data;
         if (req_ch.valid && req_ch.ready)
            pending_results.push_back(apply_request(req_ch.opcode, req_ch.target_high,
               req_ch.target_low, req_ch.iid, req_ch.locator, req_ch.router_num));
      end
      expected_count <= pending_results.size();
   end

endmodule

[tb/address_resolution_cache_core_tb.sv]
// top of the address resolution cache testbench: clock, reset, request words and verdict
// depends on arc_pkg, arc_req_if, arc_rsp_if, arc_table_checker and the core
module address_resolution_cache_core_tb import arc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ENTRY_COUNT  = 8;
   localparam int          POOL_SIZE    = 12;
   localparam int          PHASE_WORDS  = 300;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          CYCLE_LIMIT  = 500000;

   localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [ADDR_W-1:0]   hi;
      logic [ADDR_W-1:0]   lo;
      logic [IID_W-1:0]    iid;
      logic [LOC_W-1:0]    loc;
      logic [RID_W-1:0]    rid;
   } arc_request_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;
   int               idle_pct = 25;
   int               stall_pct = 53;
   int               mismatch_count;
   int               expected_count;
   int               cycle_count = 0;

   logic [ADDR_W-1:0] pool_hi  [POOL_SIZE];
   logic [ADDR_W-1:0] pool_lo  [POOL_SIZE];
   logic [IID_W-1:0]  pool_iid [POOL_SIZE];
   logic [LOC_W-1:0]  pool_loc [POOL_SIZE];

   arc_req_if req_if();
   arc_rsp_if rsp_if();

   address_resolution_cache_core #(.ENTRIES(ENTRY_COUNT)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   arc_table_checker #(.ENTRIES(ENTRY_COUNT)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .expected_count (expected_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("address_resolution_cache_core test failed");
         $finish;
      end
   end

   function automatic logic [63:0] random_wide();
      return {$urandom, $urandom};
   endfunction

   function automatic arc_request_type make_request(
      input logic [OPCODE_W-1:0] op,
      input logic [ADDR_W-1:0]   hi,
      input logic [ADDR_W-1:0]   lo,
      input logic [IID_W-1:0]    iid,
      input logic [LOC_W-1:0]    loc,
      input logic [RID_W-1:0]    rid
   );
      arc_request_type rq;
      rq.op  = op;
      rq.hi  = hi;
      rq.lo  = lo;
      rq.iid = iid;
      rq.loc = loc;
      rq.rid = rid;
      return rq;
   endfunction

   // targets that share one half test both halves of the compare
   task automatic fill_pool();
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_hi[k]  = random_wide();
         pool_lo[k]  = random_wide();
         pool_iid[k] = random_wide();
         pool_loc[k] = LOC_W'($urandom);
      end
      pool_hi[1] = pool_hi[0];
      pool_lo[2] = pool_lo[0];
      pool_loc[3][LOC_W-1:ROUTER_SHIFT] = pool_loc[4][LOC_W-1:ROUTER_SHIFT];
      pool_loc[5][LOC_W-1:ROUTER_SHIFT] = '0;
      pool_loc[6][LOC_W-1:ROUTER_SHIFT] = '1;
   endtask

   function automatic arc_request_type random_request();
      arc_request_type rq;
      int              pick;
      int              k;
      rq = make_request(OPCODE_W'($urandom), random_wide(), random_wide(), random_wide(),
                        LOC_W'($urandom), RID_W'($urandom));
      pick = $urandom_range(99);
      if (pick < 34) rq.op = OP_RESOLVE;
      else if (pick < 60) rq.op = OP_NOTIFY;
      else if (pick < 75) rq.op = OP_TICK;
      else if (pick < 85) rq.op = OP_UNREACH;
      else if (pick < 93) rq.op = OP_REMOVE;
      else if (pick < 96) rq.op = OP_CLEAR;
      else if (pick < 98) rq.op = OP_SPARE_A;
      else rq.op = OP_SPARE_B;
      if ($urandom_range(99) < 88) begin
         k = $urandom_range(POOL_SIZE - 1);
         rq.hi = pool_hi[k];
         rq.lo = pool_lo[k];
      end
      if ($urandom_range(99) < 80) rq.iid = pool_iid[$urandom_range(3)];
      if ($urandom_range(99) < 80) rq.loc = pool_loc[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(99) < 75) begin
         k = $urandom_range(POOL_SIZE - 1);
         rq.rid = pool_loc[k][LOC_W-1:ROUTER_SHIFT];
      end
      return rq;
   endfunction

   task automatic send_request(input arc_request_type rq);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.opcode      <= rq.op;
      req_if.target_high <= rq.hi;
      req_if.target_low  <= rq.lo;
      req_if.iid         <= rq.iid;
      req_if.locator     <= rq.loc;
      req_if.router_num  <= rq.rid;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_count != 0);
   endtask

   task automatic write_timeout(input logic [CNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_if.valid       <= 1'b0;
      req_if.opcode      <= '0;
      req_if.target_high <= '0;
      req_if.target_low  <= '0;
      req_if.iid         <= '0;
      req_if.locator     <= '0;
      req_if.router_num  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      fill_pool();

      // directed words at the reset timeout of three
      send_request(make_request(OP_RESOLVE, pool_hi[0], pool_lo[0], '0, '0, '0));
      send_request(make_request(OP_RESOLVE, pool_hi[0], pool_lo[0], '0, '0, '0));
      send_request(make_request(OP_NOTIFY, pool_hi[0], pool_lo[0], pool_iid[0], pool_loc[0],
                                '0));
      send_request(make_request(OP_RESOLVE, pool_hi[0], pool_lo[0], '0, '0, '0));
      send_request(make_request(OP_NOTIFY, pool_hi[0], pool_lo[0], pool_iid[1], pool_loc[1],
                                '0));
      send_request(make_request(OP_RESOLVE, pool_hi[1], pool_lo[1], '0, '0, '0));
      repeat (3) send_request(make_request(OP_TICK, '0, '0, '0, '0, '0));
      // stale target in an invalid entry still takes a notify
      send_request(make_request(OP_NOTIFY, pool_hi[1], pool_lo[1], '1, '1, '0));
      send_request(make_request(OP_REMOVE, '1, '1, '1, '1, '1));
      send_request(make_request(OP_UNREACH, pool_hi[0], pool_lo[0], '0, '0, '0));
      send_request(make_request(OP_UNREACH, pool_hi[0], pool_lo[0], '0, '0, '0));
      for (int k = 2; k <= 10; k++)
         send_request(make_request(OP_RESOLVE, pool_hi[k], pool_lo[k], '0, '0, '0));
      send_request(make_request(OP_SPARE_A, pool_hi[2], pool_lo[2], '1, '1, '1));
      send_request(make_request(OP_SPARE_B, pool_hi[3], pool_lo[3], '1, '1, '1));
      send_request(make_request(OP_CLEAR, '0, '0, '0, '0, '0));
      send_request(make_request(OP_NOTIFY, '0, '0, '0, '0, '0));
      send_request(make_request(OP_RESOLVE, '1, '1, '1, '1, '1));
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0, 1: begin
               idle_pct  = 25;
               stall_pct = 53;
            end
            2, 3: begin
               idle_pct  = 53;
               stall_pct = 25;
            end
            default: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
         endcase
         case (ph)
            0: write_timeout('0);
            1: write_timeout('1);
            3: write_timeout(CNT_W'(1));
            4: write_timeout(CNT_W'(2));
            default: write_timeout(CNT_W'($urandom_range(254, 2)));
         endcase
         fill_pool();
         repeat (PHASE_WORDS) send_request(random_request());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_count == 0) begin
         $display("address_resolution_cache_core test passed");
      end else begin
         $display("address_resolution_cache_core test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/arc_pkg.sv
sv/arc_req_if.sv
sv/arc_rsp_if.sv
sv/address_resolution_cache_core.sv
tb/arc_table_checker.sv
tb/address_resolution_cache_core_tb.sv
